/* hdl/csem_pkg.sv */
// shared types and constants for the counting semaphore table
`default_nettype none

package csem_pkg;

  localparam int NumSems         = 16;
  localparam int IdxW            = $clog2(NumSems);
  localparam int CountW          = 16;
  localparam int PidW            = 8;
  localparam int QueueDepthDflt  = 8;
  localparam int KindW           = 3;
  localparam int StatusW         = 3;
  localparam int InDataW         = 32;
  localparam int OutDataW        = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [KindW-1:0] {
    KIND_CREATE = 3'd0,
    KIND_WAIT   = 3'd1,
    KIND_POST   = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_BLOCKED    = 3'd1,
    ST_WOKE       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_NO_SLOT    = 3'd4,
    ST_QUEUE_FULL = 3'd5,
    ST_SATURATED  = 3'd6
  } status_e;

endpackage

`default_nettype wire

/* hdl/counting_semaphore_table.sv */
// table of counting semaphores, each with a fifo of waiting process ids
`default_nettype none

// One operation (create, wait, post, delete, read count) is accepted per clock
// cycle and its result word is presented from the output register: the word is
// captured in an input register, the slot table is updated in a single pass of
// logic, and the result is captured in an output register together with the
// registered read of the waiter memory. The sustained rate is one word per
// cycle; back-pressure on the result side stalls the input register, which
// still takes one more word while a result waits. Create claims the lowest
// free slot. The waiter memory holds QUEUE_DEPTH ids per slot and needs no
// clearing after reset; every other table entry resets to zero at once.
module counting_semaphore_table #(
  parameter int QUEUE_DEPTH = csem_pkg::QueueDepthDflt
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // sem_index [3:0], start_value [19:4], process_id [27:20], zero [31:28]
  input  wire logic [csem_pkg::InDataW-1:0]   s_axis_tdata,
  // kind [2:0]
  input  wire logic [csem_pkg::KindW-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // slot_out [3:0], count_out [19:4], woken_process [27:20], zero [31:28]
  output logic [csem_pkg::OutDataW-1:0]       m_axis_tdata,
  // status [2:0]
  output logic [csem_pkg::StatusW-1:0]        m_axis_tuser
);
  import csem_pkg::*;

  localparam int HeadW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW   = FillW + 1;
  localparam int MemD   = NumSems * QUEUE_DEPTH;
  localparam int AddrW  = (MemD > 1) ? $clog2(MemD) : 1;

  localparam logic [FillW-1:0] FillFull = FillW'(QUEUE_DEPTH);
  localparam logic [HeadW-1:0] HeadLast = HeadW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0]  DepthS   = SumW'(QUEUE_DEPTH);

  // input register
  logic                in_valid_q;
  logic [KindW-1:0]    in_kind_q;
  logic [IdxW-1:0]     in_idx_q;
  logic [CountW-1:0]   in_start_q;
  logic [PidW-1:0]     in_pid_q;

  // slot table
  logic                in_use_q [NumSems];
  logic                in_use_d [NumSems];
  logic [CountW-1:0]   count_q  [NumSems];
  logic [CountW-1:0]   count_d  [NumSems];
  logic [HeadW-1:0]    head_q   [NumSems];
  logic [HeadW-1:0]    head_d   [NumSems];
  logic [FillW-1:0]    fill_q   [NumSems];
  logic [FillW-1:0]    fill_d   [NumSems];

  // waiter memory
  logic [PidW-1:0]     waiter_mem [MemD];
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [AddrW-1:0]    mem_raddr;
  logic [PidW-1:0]     mem_rdata_q;

  // result register
  logic                out_valid_q;
  status_e             res_status_q;
  status_e             res_status_d;
  logic [IdxW-1:0]     res_slot_q;
  logic [IdxW-1:0]     res_slot_d;
  logic [CountW-1:0]   res_count_q;
  logic [CountW-1:0]   res_count_d;

  logic                out_load;
  logic                advance;

  logic                found;
  logic [IdxW-1:0]     free_slot;
  logic [CountW-1:0]   cur_count;
  logic [HeadW-1:0]    cur_head;
  logic [FillW-1:0]    cur_fill;
  logic [SumW-1:0]     tail_sum;
  logic [HeadW-1:0]    tail_pos;
  logic [AddrW-1:0]    slot_base;

  assign out_load      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_load;
  assign s_axis_tready = !in_valid_q || out_load;

  assign cur_count = count_q[in_idx_q];
  assign cur_head  = head_q[in_idx_q];
  assign cur_fill  = fill_q[in_idx_q];

  // ring position of the next free entry, head + fill stays below twice the depth
  assign tail_sum  = SumW'(cur_head) + SumW'(cur_fill);
  assign tail_pos  = (tail_sum >= DepthS) ? HeadW'(tail_sum - DepthS) : HeadW'(tail_sum);
  assign slot_base = AddrW'(AddrW'(in_idx_q) * AddrW'(QUEUE_DEPTH));
  assign mem_raddr = AddrW'(slot_base + AddrW'(cur_head));

  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int s = 0; s < NumSems; s++) begin
      if (!found && !in_use_q[s]) begin
        found     = 1'b1;
        free_slot = IdxW'(s);
      end
    end
  end

  always_comb begin
    in_use_d     = in_use_q;
    count_d      = count_q;
    head_d       = head_q;
    fill_d       = fill_q;
    mem_we       = 1'b0;
    mem_waddr    = AddrW'(slot_base + AddrW'(tail_pos));
    res_status_d = ST_NOT_FOUND;
    res_slot_d   = in_idx_q;
    res_count_d  = '0;

    case (in_kind_q)
      KIND_CREATE: begin
        res_slot_d = '0;
        if (found) begin
          in_use_d[free_slot] = 1'b1;
          count_d[free_slot]  = in_start_q;
          head_d[free_slot]   = '0;
          fill_d[free_slot]   = '0;
          res_status_d        = ST_OK;
          res_slot_d          = free_slot;
          res_count_d         = in_start_q;
        end else begin
          res_status_d = ST_NO_SLOT;
        end
      end
      KIND_WAIT: begin
        if (in_use_q[in_idx_q]) begin
          res_count_d = cur_count;
          if (cur_count != '0) begin
            count_d[in_idx_q] = cur_count - CountW'(1);
            res_count_d       = cur_count - CountW'(1);
            res_status_d      = ST_OK;
          end else if (cur_fill == FillFull) begin
            res_status_d = ST_QUEUE_FULL;
          end else begin
            mem_we           = 1'b1;
            fill_d[in_idx_q] = cur_fill + FillW'(1);
            res_status_d     = ST_BLOCKED;
          end
        end
      end
      KIND_POST: begin
        if (in_use_q[in_idx_q]) begin
          res_count_d = cur_count;
          if (cur_fill != '0) begin
            head_d[in_idx_q] = (cur_head == HeadLast) ? '0 : cur_head + HeadW'(1);
            fill_d[in_idx_q] = cur_fill - FillW'(1);
            res_status_d     = ST_WOKE;
          end else if (cur_count == CountMax) begin
            res_status_d = ST_SATURATED;
          end else begin
            count_d[in_idx_q] = cur_count + CountW'(1);
            res_count_d       = cur_count + CountW'(1);
            res_status_d      = ST_OK;
          end
        end
      end
      KIND_DELETE: begin
        if (in_use_q[in_idx_q]) begin
          in_use_d[in_idx_q] = 1'b0;
          count_d[in_idx_q]  = '0;
          head_d[in_idx_q]   = '0;
          fill_d[in_idx_q]   = '0;
          res_status_d       = ST_OK;
        end
      end
      KIND_READ: begin
        if (in_use_q[in_idx_q]) begin
          res_count_d  = cur_count;
          res_status_d = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q  <= s_axis_tuser;
      in_idx_q   <= s_axis_tdata[IdxW-1:0];
      in_start_q <= s_axis_tdata[IdxW +: CountW];
      in_pid_q   <= s_axis_tdata[IdxW + CountW +: PidW];
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSems; s++) begin
        in_use_q[s] <= 1'b0;
        count_q[s]  <= '0;
        head_q[s]   <= '0;
        fill_q[s]   <= '0;
      end
    end else if (advance) begin
      in_use_q <= in_use_d;
      count_q  <= count_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
    end
  end

  // waiter memory, read data held with the result word
  always_ff @(posedge clk_i) begin
    if (advance && mem_we) begin
      waiter_mem[mem_waddr] <= in_pid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mem_rdata_q <= waiter_mem[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_count_q  <= res_count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {
    {(OutDataW - IdxW - CountW - PidW){1'b0}},
    (res_status_q == ST_WOKE) ? mem_rdata_q : {PidW{1'b0}},
    res_count_q,
    res_slot_q
  };

endmodule

`default_nettype wire

/* hdl/csem_chk.sv */
// port checks for the counting semaphore table and their bind
`default_nettype none

module csem_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [csem_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [csem_pkg::StatusW-1:0]  m_axis_tuser
);
  import csem_pkg::*;

  logic [PidW-1:0]   woken;
  logic [CountW-1:0] count;
  logic [IdxW-1:0]   slot;
  logic              in_seen;

  assign woken   = m_axis_tdata[IdxW + CountW +: PidW];
  assign count   = m_axis_tdata[IdxW +: CountW];
  assign slot    = m_axis_tdata[IdxW-1:0];
  assign in_seen = s_axis_tvalid && s_axis_tready;

  // a released id only comes with a woken status
  a_woken_only_on_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_WOKE |-> woken == '0)
    else $error("woken id without wake status");

  // failed create reports slot and count zero
  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_NO_SLOT |-> slot == '0 && count == '0)
    else $error("no free slot word carries data");

  // a missing slot never reports a count
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_NOT_FOUND |-> count == '0)
    else $error("not found word carries a count");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // an accepted word reaches the output once the result side is free
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted word did not reach the output");

endmodule

bind counting_semaphore_table csem_chk u_csem_chk (.*);

`default_nettype wire
